// ===== hw/rtl/cfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_pkg: command frame encoder shared definitions
// Frame delimiters, CRC16-CCITT byte update, job codes and the job record
// passed from the classifier to the byte sequencer.
// ----------------------------------------------------------------------------
package cfe_pkg;

   localparam logic [7:0]  FRAME_START = 8'h5B;
   localparam logic [7:0]  FRAME_END   = 8'h5D;
   localparam logic [15:0] CRC_POLY    = 16'h1021;

   localparam int QUEUE_DEPTH_DEF = 2;
   localparam int STEP_W          = 3;

   // input mode codes
   localparam logic [1:0] MODE_HEADER = 2'd0;
   localparam logic [1:0] MODE_DATA   = 2'd1;
   localparam logic [1:0] MODE_ACK    = 2'd2;

   typedef enum logic [1:0] {
      JOB_ERROR  = 2'd0,
      JOB_HEADER = 2'd1,
      JOB_DATA   = 2'd2,
      JOB_ACK    = 2'd3
   } job_kind_type;

   // closes: header with zero length, or final payload byte
   typedef struct packed {
      job_kind_type kind;
      logic         closes;
      logic [7:0]   b0;
      logic [7:0]   b1;
      logic [7:0]   b2;
      logic [7:0]   b3;
   } job_type;

   // CRC16-CCITT, MSB first, one byte
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/cfe_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_front: item classifier
// Accepts input items, tracks the open request frame and turns each item
// into one job for the byte sequencer.
// ----------------------------------------------------------------------------
module cfe_front
   import cfe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_cmd_type,
   input  logic [7:0]  req_cmd_param,
   input  logic [15:0] req_data_length,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_ack_cmd_code,
   input  logic [7:0]  req_ack_value,
   output logic        job_push,
   output job_type     job,
   input  logic        job_full
);

   logic        frame_open_ff, frame_open_in, open_nx;
   logic [15:0] bytes_left_ff, bytes_left_in, left_nx;
   logic        accept;

   assign req_full = job_full;
   assign accept   = req_push & ~job_full;
   assign job_push = accept;

   always_comb begin
      job      = '0;
      job.kind = JOB_ERROR;
      open_nx  = frame_open_ff;
      left_nx  = bytes_left_ff;
      unique case (req_mode)
         MODE_HEADER: begin
            if (!frame_open_ff) begin
               job.kind   = JOB_HEADER;
               job.b0     = req_cmd_type;
               job.b1     = req_cmd_param;
               job.b2     = req_data_length[15:8];
               job.b3     = req_data_length[7:0];
               job.closes = (req_data_length == 16'd0);
               open_nx    = (req_data_length != 16'd0);
               left_nx    = req_data_length;
            end
         end
         MODE_DATA: begin
            if (frame_open_ff) begin
               job.kind   = JOB_DATA;
               job.b0     = req_data_byte;
               job.closes = (bytes_left_ff == 16'd1);
               open_nx    = (bytes_left_ff != 16'd1);
               left_nx    = bytes_left_ff - 16'd1;
            end
         end
         MODE_ACK: begin
            if (!frame_open_ff) begin
               job.kind = JOB_ACK;
               job.b0   = req_ack_cmd_code;
               job.b1   = req_ack_value;
            end
         end
         default: begin
            job.kind = JOB_ERROR;
         end
      endcase
   end

   assign frame_open_in = accept ? open_nx : frame_open_ff;
   assign bytes_left_in = accept ? left_nx : bytes_left_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff <= 1'b0;
         bytes_left_ff <= 16'd0;
      end else begin
         frame_open_ff <= frame_open_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

   a_open_tracks_count: assert property (@(posedge clock) disable iff (reset)
      frame_open_ff == (bytes_left_ff != 16'd0))
      else $error("frame_open out of step with bytes_left");

endmodule

// ===== hw/rtl/cfe_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_queue: job queue
// Short register queue between classifier and byte sequencer.
// ----------------------------------------------------------------------------
module cfe_queue
   import cfe_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign pop_job = mem[rd_ptr_ff];

   assign wr_ptr_in = do_push ? ((wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1) : wr_ptr_ff;
   assign rd_ptr_in = do_pop  ? ((rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("job queue pointers disagree with count");

endmodule

// ===== hw/rtl/cfe_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfe_back: byte sequencer
// Expands one job into frame bytes, one per cycle unless rsp stalls, running
// the CRC over covered bytes; closing jobs append ~CRC and the end delimiter.
// ----------------------------------------------------------------------------
module cfe_back
   import cfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       job_valid,
   input  job_type    job,
   output logic       job_pop,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_last,
   output logic       rsp_frame_done,
   output logic       rsp_error
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic [15:0]       crc_ff, crc_in, crc_inv;
   logic              valid_ff, valid_in;
   logic [7:0]        tx_byte_ff;
   logic              last_ff, done_ff, error_ff;

   logic       fire;
   logic [7:0] byte_s;
   logic       upd, clr, fin, done, err;

   assign fire    = job_valid & (~valid_ff | rsp_pop);
   assign job_pop = fire & fin;
   assign crc_inv = ~crc_ff;

   // queue head is stale while empty and is ignored
   always_comb begin
      byte_s = 8'h00;
      upd    = 1'b0;
      clr    = 1'b0;
      fin    = 1'b0;
      done   = 1'b0;
      err    = 1'b0;
      if (job_valid) begin
         unique case (job.kind)
            JOB_ERROR: begin
               fin = 1'b1;
               err = 1'b1;
            end
            JOB_HEADER: begin
               case (step_ff)
                  3'd0: begin byte_s = FRAME_START; clr = 1'b1; end
                  3'd1: begin byte_s = job.b0; upd = 1'b1; end
                  3'd2: begin byte_s = job.b1; upd = 1'b1; end
                  3'd3: begin byte_s = job.b2; upd = 1'b1; end
                  3'd4: begin byte_s = job.b3; upd = 1'b1; fin = ~job.closes; end
                  3'd5: byte_s = crc_inv[15:8];
                  3'd6: byte_s = crc_inv[7:0];
                  3'd7: begin byte_s = FRAME_END; fin = 1'b1; done = 1'b1; end
               endcase
            end
            JOB_DATA: begin
               case (step_ff)
                  3'd0: begin byte_s = job.b0; upd = 1'b1; fin = ~job.closes; end
                  3'd1: byte_s = crc_inv[15:8];
                  3'd2: byte_s = crc_inv[7:0];
                  3'd3: begin byte_s = FRAME_END; fin = 1'b1; done = 1'b1; end
                  default: fin = 1'b1;
               endcase
            end
            JOB_ACK: begin
               case (step_ff)
                  3'd0: begin byte_s = FRAME_START; clr = 1'b1; end
                  3'd1: begin byte_s = job.b0; upd = 1'b1; end
                  3'd2: begin byte_s = job.b1; upd = 1'b1; end
                  3'd3: byte_s = crc_inv[15:8];
                  3'd4: byte_s = crc_inv[7:0];
                  3'd5: begin byte_s = FRAME_END; fin = 1'b1; done = 1'b1; end
                  default: fin = 1'b1;
               endcase
            end
         endcase
      end
   end

   always_comb begin
      crc_in = crc_ff;
      if (fire && clr) begin
         crc_in = 16'h0000;
      end else if (fire && upd) begin
         crc_in = crc16_byte(crc_ff, byte_s);
      end
   end

   assign step_in  = fire ? (fin ? '0 : step_ff + 1'b1) : step_ff;
   assign valid_in = fire | (valid_ff & ~rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         crc_ff   <= 16'h0000;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         crc_ff   <= crc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         tx_byte_ff <= byte_s;
         last_ff    <= fin;
         done_ff    <= done;
         error_ff   <= err;
      end
   end

   assign rsp_empty      = ~valid_ff;
   assign rsp_tx_byte    = tx_byte_ff;
   assign rsp_last       = last_ff;
   assign rsp_frame_done = done_ff;
   assign rsp_error      = error_ff;

   a_error_shape: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && error_ff) |-> (last_ff && !done_ff && tx_byte_ff == 8'h00))
      else $error("error transfer malformed");

   a_done_shape: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && done_ff) |-> (last_ff && tx_byte_ff == FRAME_END))
      else $error("frame end transfer malformed");

endmodule

// ===== hw/rtl/crc16_command_frame_encoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_command_frame_encoder_top: serial command frame encoder
// Turns header, payload and acknowledge items into framed bytes with an
// inverted CRC16-CCITT trailer.
// ----------------------------------------------------------------------------
//  channel   | handshake         | transfer
//  req       | req_push/req_full | one item: mode plus header, data or ack fields
//  rsp       | rsp_pop/rsp_empty | one frame byte with last, frame_done, error
//
//  The sequencer emits one byte per cycle unless rsp stalls: header 5 or 8
//  bytes, payload byte 1 or 4, acknowledge 6, misplaced item 1. The first
//  byte reaches rsp via the job queue and output register. A QUEUE_DEPTH
//  entry queue lets input run ahead; a stalled rsp holds the sequencer, not
//  the input until the queue fills. Synchronous reset closes any open frame.
// ----------------------------------------------------------------------------
module crc16_command_frame_encoder_top
   import cfe_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_cmd_type,
   input  logic [7:0]  req_cmd_param,
   input  logic [15:0] req_data_length,
   input  logic [7:0]  req_data_byte,
   input  logic [7:0]  req_ack_cmd_code,
   input  logic [7:0]  req_ack_value,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_last,
   output logic        rsp_frame_done,
   output logic        rsp_error
);

   job_type in_job, out_job;
   logic    in_push, q_full, q_pop, q_empty;

   cfe_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_mode         (req_mode),
      .req_cmd_type     (req_cmd_type),
      .req_cmd_param    (req_cmd_param),
      .req_data_length  (req_data_length),
      .req_data_byte    (req_data_byte),
      .req_ack_cmd_code (req_ack_cmd_code),
      .req_ack_value    (req_ack_value),
      .job_push         (in_push),
      .job              (in_job),
      .job_full         (q_full)
   );

   cfe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (in_push),
      .push_job (in_job),
      .full     (q_full),
      .pop      (q_pop),
      .pop_job  (out_job),
      .empty    (q_empty)
   );

   cfe_back u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (~q_empty),
      .job            (out_job),
      .job_pop        (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_last       (rsp_last),
      .rsp_frame_done (rsp_frame_done),
      .rsp_error      (rsp_error)
   );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for crc16_command_frame_encoder_top
// Drives header, payload, acknowledge and misplaced items through the push/full
// queue and pops frame bytes with random idle gaps on both sides. A directed
// table comes first, then random frames. Each popped byte is compared with
// table bytes or a local encoder with its own open-frame state and running CRC.
// ----------------------------------------------------------------------------
module tb;
   import cfe_pkg::*;

   localparam logic [1:0] MODE_UNUSED    = 2'd3;
   localparam int         DIRECTED_ROWS  = 22;
   localparam int         RANDOM_ITEMS   = 280;
   localparam int         TAIL_BYTES     = 12;
   localparam int         HOLD_CYCLES    = 400;
   localparam int         HOLD_AFTER     = 150;
   localparam int         DRAIN_CYCLES   = 20;
   localparam int         WATCHDOG_LIMIT = 3000;
   localparam int         MAX_REPORTS    = 10;

   typedef enum logic [1:0] {
      CHK_MODEL = 2'd0,
      CHK_ERROR = 2'd1,
      CHK_BYTES = 2'd2
   } check_kind_t;

   typedef struct {
      logic [1:0]  mode;
      logic [7:0]  cmd_type;
      logic [7:0]  cmd_param;
      logic [15:0] data_length;
      logic [7:0]  data_byte;
      logic [7:0]  ack_cmd_code;
      logic [7:0]  ack_value;
      check_kind_t check;
      int          n_bytes;
      logic [63:0] bytes;
   } stim_t;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
      logic       frame_done;
      logic       error;
   } tx_result_t;

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   logic [1:0]  req_mode;
   logic [7:0]  req_cmd_type;
   logic [7:0]  req_cmd_param;
   logic [15:0] req_data_length;
   logic [7:0]  req_data_byte;
   logic [7:0]  req_ack_cmd_code;
   logic [7:0]  req_ack_value;
   logic        rsp_empty;
   logic        rsp_pop;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_last;
   logic        rsp_frame_done;
   logic        rsp_error;

   crc16_command_frame_encoder_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_mode         (req_mode),
      .req_cmd_type     (req_cmd_type),
      .req_cmd_param    (req_cmd_param),
      .req_data_length  (req_data_length),
      .req_data_byte    (req_data_byte),
      .req_ack_cmd_code (req_ack_cmd_code),
      .req_ack_value    (req_ack_value),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_last         (rsp_last),
      .rsp_frame_done   (rsp_frame_done),
      .rsp_error        (rsp_error)
   );

   // encoder state as seen by the checker
   logic        enc_open;
   logic [15:0] enc_left;
   logic [15:0] enc_crc;

   // frame state as planned by the stimulus generator
   logic        plan_open;
   logic [15:0] plan_left;

   stim_t       cur_stim;
   tx_result_t  tx_expected[$];
   int          mismatch_count;
   int          idle_cycles;
   bit          sender_burst;
   bit          receiver_burst;
   int          big_frames_left;
   stim_t       directed_table [DIRECTED_ROWS];

   always #1 clock = ~clock;

   function automatic stim_t row(input logic [1:0] mode, input logic [7:0] t,
                                 input logic [7:0] p, input logic [15:0] len,
                                 input logic [7:0] d, input logic [7:0] code,
                                 input logic [7:0] val, input check_kind_t check,
                                 input int n, input logic [63:0] bytes);
      stim_t s;
      s.mode         = mode;
      s.cmd_type     = t;
      s.cmd_param    = p;
      s.data_length  = len;
      s.data_byte    = d;
      s.ack_cmd_code = code;
      s.ack_value    = val;
      s.check        = check;
      s.n_bytes      = n;
      s.bytes        = bytes;
      return s;
   endfunction

   function automatic logic [15:0] crc_ccitt_update(input logic [15:0] crc,
                                                    input logic [7:0] b);
      logic [15:0] c;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         if (c[15] ^ b[i]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic tx_result_t tx_plain(input logic [7:0] b);
      tx_result_t r;
      r.tx_byte    = b;
      r.last       = 1'b0;
      r.frame_done = 1'b0;
      r.error      = 1'b0;
      return r;
   endfunction

   function automatic void encode_item(input stim_t s, output tx_result_t res[$]);
      logic [15:0] c;
      logic        closing;
      tx_result_t  r;
      res     = {};
      closing = 1'b0;
      c       = 16'h0000;
      if (s.mode == MODE_HEADER && !enc_open) begin
         c = crc_ccitt_update(c, s.cmd_type);
         c = crc_ccitt_update(c, s.cmd_param);
         c = crc_ccitt_update(c, s.data_length[15:8]);
         c = crc_ccitt_update(c, s.data_length[7:0]);
         res.push_back(tx_plain(FRAME_START));
         res.push_back(tx_plain(s.cmd_type));
         res.push_back(tx_plain(s.cmd_param));
         res.push_back(tx_plain(s.data_length[15:8]));
         res.push_back(tx_plain(s.data_length[7:0]));
         if (s.data_length == 16'h0000) begin
            closing = 1'b1;
         end else begin
            enc_open = 1'b1;
            enc_left = s.data_length;
            enc_crc  = c;
         end
      end else if (s.mode == MODE_DATA && enc_open) begin
         enc_crc = crc_ccitt_update(enc_crc, s.data_byte);
         res.push_back(tx_plain(s.data_byte));
         enc_left = enc_left - 16'd1;
         if (enc_left == 16'h0000) begin
            closing  = 1'b1;
            c        = enc_crc;
            enc_open = 1'b0;
         end
      end else if (s.mode == MODE_ACK && !enc_open) begin
         c = crc_ccitt_update(crc_ccitt_update(16'h0000, s.ack_cmd_code), s.ack_value);
         res.push_back(tx_plain(FRAME_START));
         res.push_back(tx_plain(s.ack_cmd_code));
         res.push_back(tx_plain(s.ack_value));
         closing = 1'b1;
      end else begin
         r       = tx_plain(8'h00);
         r.last  = 1'b1;
         r.error = 1'b1;
         res.push_back(r);
         return;
      end
      if (closing) begin
         c = ~c;
         res.push_back(tx_plain(c[15:8]));
         res.push_back(tx_plain(c[7:0]));
         r            = tx_plain(FRAME_END);
         r.frame_done = 1'b1;
         res.push_back(r);
      end
      res[res.size() - 1].last = 1'b1;
   endfunction

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("[%0t] bad result: %s", $realtime, msg);
      end
   endtask

   // transfer tracking and checking
   always @(posedge clock) begin
      tx_result_t produced[$];
      tx_result_t got;
      tx_result_t want;
      if (!reset) begin
         if (req_push && !req_full) begin
            encode_item(cur_stim, produced);
            if (cur_stim.check == CHK_MODEL) begin
               foreach (produced[i]) tx_expected.push_back(produced[i]);
            end else if (cur_stim.check == CHK_ERROR) begin
               want       = tx_plain(8'h00);
               want.last  = 1'b1;
               want.error = 1'b1;
               tx_expected.push_back(want);
            end else begin
               for (int i = 0; i < cur_stim.n_bytes; i++) begin
                  want = tx_plain(cur_stim.bytes[63 - 8 * i -: 8]);
                  if (i == cur_stim.n_bytes - 1) begin
                     want.last       = 1'b1;
                     want.frame_done = 1'b1;
                  end
                  tx_expected.push_back(want);
               end
            end
         end
         if (rsp_pop && !rsp_empty) begin
            got = {rsp_tx_byte, rsp_last, rsp_frame_done, rsp_error};
            if (tx_expected.size() == 0) begin
               note_mismatch($sformatf("unexpected byte %02h last %b done %b err %b",
                                       got.tx_byte, got.last, got.frame_done, got.error));
            end else begin
               want = tx_expected.pop_front();
               if (got !== want) begin
                  note_mismatch($sformatf(
                     "exp byte %02h last %b done %b err %b, got %02h %b %b %b",
                     want.tx_byte, want.last, want.frame_done, want.error,
                     got.tx_byte, got.last, got.frame_done, got.error));
               end
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("crc16_command_frame_encoder_top: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int draw_gap(input bit burst);
      if (burst) begin
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic drive_item(input stim_t s);
      int gap;
      if ($urandom_range(0, 11) == 0) sender_burst = ~sender_burst;
      gap = draw_gap(sender_burst);
      if (plan_open && s.mode == MODE_HEADER) begin
      end
      if (s.mode == MODE_HEADER && !plan_open && s.data_length != 16'h0000) begin
         plan_open = 1'b1;
         plan_left = s.data_length;
      end else if (s.mode == MODE_DATA && plan_open) begin
         plan_left = plan_left - 16'd1;
         if (plan_left == 16'h0000) plan_open = 1'b0;
      end
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      cur_stim         = s;
      req_push         <= 1'b1;
      req_mode         <= s.mode;
      req_cmd_type     <= s.cmd_type;
      req_cmd_param    <= s.cmd_param;
      req_data_length  <= s.data_length;
      req_data_byte    <= s.data_byte;
      req_ack_cmd_code <= s.ack_cmd_code;
      req_ack_value    <= s.ack_value;
      do @(posedge clock); while (req_full);
      @(negedge clock);
   endtask

   function automatic stim_t random_stim(input logic [1:0] mode);
      return row(mode, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                 8'($urandom), 8'($urandom), CHK_MODEL, 0, 64'h0);
   endfunction

   function automatic logic [15:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 2 && big_frames_left > 0) begin
         big_frames_left--;
         return 16'h0100 + 16'($urandom_range(0, 15));
      end
      if (r < 20) begin
         return 16'($urandom_range(7, 40));
      end
      return 16'($urandom_range(0, 6));
   endfunction

   // receiver: random pop gaps, one long hold-off to back up the input
   initial begin
      int  gap;
      int  pops_seen;
      bit  hold_done;
      pops_seen = 0;
      hold_done = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 11) == 0) receiver_burst = ~receiver_burst;
         gap = draw_gap(receiver_burst);
         if (!hold_done && pops_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            gap       = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         pops_seen++;
         @(negedge clock);
      end
   end

   initial begin
      stim_t s;
      int    sent;
      int    pick;
      clock            = 1'b0;
      reset            = 1'b1;
      req_push         = 1'b0;
      req_mode         = MODE_HEADER;
      req_cmd_type     = 8'h00;
      req_cmd_param    = 8'h00;
      req_data_length  = 16'h0000;
      req_data_byte    = 8'h00;
      req_ack_cmd_code = 8'h00;
      req_ack_value    = 8'h00;
      rsp_pop          = 1'b0;
      enc_open         = 1'b0;
      enc_left         = 16'h0000;
      enc_crc          = 16'h0000;
      plan_open        = 1'b0;
      plan_left        = 16'h0000;
      mismatch_count   = 0;
      idle_cycles      = 0;
      sender_burst     = 1'b0;
      receiver_burst   = 1'b0;
      big_frames_left  = 1;

      directed_table = '{
         row(MODE_HEADER, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00,
             CHK_BYTES, 8, 64'h5B00_0000_00FF_FF5D),
         row(MODE_DATA, 8'h00, 8'h00, 16'h0000, 8'hFF, 8'h00, 8'h00, CHK_ERROR, 1, 64'h0),
         row(MODE_UNUSED, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, CHK_ERROR, 1, 64'h0),
         row(MODE_ACK, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00,
             CHK_BYTES, 6, 64'h5B00_00FF_FF5D_0000),
         row(MODE_ACK, 8'h00, 8'h00, 16'h0000, 8'h00, 8'hFF, 8'hFF, CHK_MODEL, 0, 64'h0),
         row(MODE_HEADER, 8'hFF, 8'hFF, 16'h0002, 8'hFF, 8'hFF, 8'hFF, CHK_MODEL, 0, 64'h0),
         row(MODE_HEADER, 8'h11, 8'h22, 16'h0000, 8'h00, 8'h00, 8'h00, CHK_ERROR, 1, 64'h0),
         row(MODE_ACK, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h12, 8'h34, CHK_ERROR, 1, 64'h0),
         row(MODE_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, CHK_ERROR, 1, 64'h0),
         row(MODE_DATA, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, CHK_MODEL, 0, 64'h0),
         row(MODE_DATA, 8'h00, 8'h00, 16'h0000, 8'hFF, 8'h00, 8'h00, CHK_MODEL, 0, 64'h0),
         row(MODE_DATA, 8'h00, 8'h00, 16'h0000, 8'h42, 8'h00, 8'h00, CHK_ERROR, 1, 64'h0),
         row(MODE_HEADER, 8'hA5, 8'h5A, 16'h0001, 8'hFF, 8'hFF, 8'hFF, CHK_MODEL, 0, 64'h0),
         row(MODE_DATA, 8'hFF, 8'hFF, 16'hFFFF, 8'h3C, 8'hFF, 8'hFF, CHK_MODEL, 0, 64'h0),
         row(MODE_HEADER, 8'h12, 8'h34, 16'h0003, 8'h00, 8'h00, 8'h00, CHK_MODEL, 0, 64'h0),
         row(MODE_DATA, 8'h00, 8'h00, 16'h0000, 8'h80, 8'h00, 8'h00, CHK_MODEL, 0, 64'h0),
         row(MODE_ACK, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h55, 8'hAA, CHK_ERROR, 1, 64'h0),
         row(MODE_DATA, 8'h00, 8'h00, 16'h0000, 8'h01, 8'h00, 8'h00, CHK_MODEL, 0, 64'h0),
         row(MODE_DATA, 8'h00, 8'h00, 16'h0000, 8'h7F, 8'h00, 8'h00, CHK_MODEL, 0, 64'h0),
         row(MODE_ACK, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'h80, 8'h01, CHK_MODEL, 0, 64'h0),
         row(MODE_HEADER, 8'h00, 8'hFF, 16'h0000, 8'hFF, 8'hFF, 8'hFF, CHK_MODEL, 0, 64'h0),
         row(MODE_UNUSED, 8'h00, 8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, CHK_ERROR, 1, 64'h0)
      };

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_table[i]) drive_item(directed_table[i]);

      // random frames: mostly well-formed, some misplaced items
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (plan_open) begin
            s = random_stim((pick < 88) ? MODE_DATA : 2'($urandom_range(0, 3)));
         end else if (pick < 55) begin
            s = random_stim(MODE_HEADER);
            s.data_length = pick_length();
         end else if (pick < 80) begin
            s = random_stim(MODE_ACK);
         end else begin
            s = random_stim(2'($urandom_range(0, 3)));
         end
         if (s.mode == MODE_HEADER) s.data_length = pick_length();
         drive_item(s);
         sent++;
      end
      while (plan_open) drive_item(random_stim(MODE_DATA));

      // longest length: the frame stays open to the end
      s = random_stim(MODE_HEADER);
      s.data_length = 16'hFFFF;
      drive_item(s);
      repeat (TAIL_BYTES) drive_item(random_stim(MODE_DATA));
      req_push <= 1'b0;

      while (tx_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("crc16_command_frame_encoder_top: match");
      end else begin
         $display("crc16_command_frame_encoder_top: mismatch");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/cfe_pkg.sv
hw/rtl/cfe_front.sv
hw/rtl/cfe_queue.sv
hw/rtl/cfe_back.sv
hw/rtl/crc16_command_frame_encoder_top.sv
tb/sv/tb.sv
